/* hdl/qdem_pkg.sv */
// Shared constants, stage map and pipeline record for the quaternion drift unit.
`timescale 1ns / 1ps

package qdem_pkg;

    localparam int IN_TDATA_W  = 320;
    localparam int OUT_TDATA_W = 128;

    // Stage map of the datapath; each ST_ entry is the index of a register stage.
    localparam int ST_IN       = 0;
    localparam int ST_PM       = 1;
    localparam int ST_W        = 2;
    localparam int ST_SQ       = 3;
    localparam int ST_SUMSQ    = 4;
    localparam int ST_SQRT     = 5;
    localparam int SQRT_STAGES = 16;
    localparam int ST_P        = ST_SQRT + SQRT_STAGES;
    localparam int ST_PP       = ST_P + 1;
    localparam int ST_MID      = ST_PP + 1;
    localparam int ST_TURN     = ST_MID + 1;
    localparam int ST_FOLD     = ST_TURN + 1;
    localparam int ST_X        = ST_FOLD + 1;
    localparam int ST_X2       = ST_X + 1;
    localparam int ST_TRIG     = ST_X2 + 1;
    localparam int TRIG_SLOTS  = 6;
    localparam int ST_SIN      = ST_TRIG + 3 * TRIG_SLOTS;
    localparam int ST_SGN      = ST_SIN + 1;
    localparam int ST_NUM      = ST_SGN + 1;
    localparam int ST_DIV      = ST_NUM + 1;
    localparam int DIV_STAGES  = 16;
    localparam int ST_MUL      = ST_DIV + DIV_STAGES;
    localparam int ST_SUM      = ST_MUL + 1;
    localparam int ST_LAST     = ST_SUM;
    localparam int NSTAGE      = ST_LAST + 1;

    localparam logic [63:0] QTURN_C     = 64'hA2F9_836E_4E44_152A;
    localparam logic [32:0] HALF_PI_Q32 = 33'h1_921F_B544;
    localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
    localparam int          RECIP_SHIFT = 34;

    // Taylor divisors, innermost term first.
    localparam logic [7:0] COS_K [TRIG_SLOTS]     = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [7:0] SIN_K [TRIG_SLOTS - 1] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

    typedef struct packed {
        logic [3:0][31:0]  q;
        logic [2:0][31:0]  u;
        logic [2:0][31:0]  ud;
        logic [2:0]        ud_neg;
        logic [2:0][63:0]  pm;
        logic [2:0][31:0]  w;
        logic [2:0][63:0]  sq;
        logic [63:0]       sumsq;
        logic [34:0]       srem;
        logic [31:0]       mag;
        logic [63:0]       p;
        logic [3:0][63:0]  pp;
        logic [64:0]       mid;
        logic [1:0]        quad;
        logic [31:0]       frac;
        logic              fsel;
        logic [32:0]       arg;
        logic [31:0]       x;
        logic [31:0]       x2;
        logic [32:0]       t_cos;
        logic [32:0]       t_sin;
        logic [64:0]       prod_cos;
        logic [64:0]       prod_sin;
        logic [66:0]       mr_cos;
        logic [66:0]       mr_sin;
        logic [32:0]       sn_mag;
        logic              sn_neg;
        logic [31:0]       a;
        logic [2:0][63:0]  num;
        logic [33:0]       den;
        logic [2:0][34:0]  drem;
        logic [2:0][31:0]  quo;
        logic              mag_zero;
        logic [15:0][63:0] prod;
        logic [3:0][65:0]  sum;
    } item_t;

endpackage

/* hdl/quaternion_drift_exp_map.sv */
// Pipelined quaternion drift by the exponential map, one body per clock unless the output stalls.
`timescale 1ns / 1ps

// Usage
// The slave stream carries one body per transfer: the quaternion (Q2.30), the
// angular velocity and the angular acceleration (Q12.20). The master stream
// returns the advanced quaternion (Q2.30), one transfer for every input
// transfer, in the same order.
// The time step h (unsigned Q8.24) is loaded through cfg_wr_en/cfg_wr_data and
// must only change while no body is in flight.
// The datapath is a 67-stage pipeline followed by the output register. One
// body can be accepted every cycle while the pipeline is not held; the square
// root and the final division each retire two bits per stage, and the sine
// and cosine series take three stages per term.
// When the receiver stalls, the pipeline moves on until a finished result would
// overwrite the waiting output; it then freezes as a whole, with nothing lost or
// repeated. Reset empties the pipeline, drops m_tvalid and clears h to zero.
module quaternion_drift_exp_map (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [31:0]                           cfg_wr_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // quat_w, quat_x, quat_y, quat_z, ang_vel_x, ang_vel_y, ang_vel_z,
    // ang_acc_x, ang_acc_y, ang_acc_z
    input  logic [qdem_pkg::IN_TDATA_W-1:0]       s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // new_quat_w, new_quat_x, new_quat_y, new_quat_z
    output logic [qdem_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import qdem_pkg::*;

    logic [31:0]       step_size_reg;
    item_t             pipe_reg  [NSTAGE];
    item_t             pipe_next [NSTAGE];
    logic [NSTAGE-1:0] valid_reg;
    logic              m_tvalid_reg;
    logic [3:0][31:0]  out_reg;
    logic [3:0][31:0]  out_next;
    logic              en;

    function automatic logic [32:0] taylor_term(input logic [64:0] prod,
                                                input logic [66:0] mr,
                                                input logic [7:0]  k);
        logic [32:0] v;
        logic [32:0] q0;
        logic [32:0] rem;
        v   = prod[64:32];
        q0  = mr[66:34];
        rem = v - 33'(q0 * k);
        if (rem >= {25'd0, k})
        begin
            q0 = q0 + 33'd1;
        end
        return ONE_Q32 - q0;
    endfunction

    // The whole pipeline holds only when a finished result would overwrite a
    // result that is still waiting.
    assign en       = !(m_tvalid_reg && !m_tready && valid_reg[ST_LAST]);
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            step_size_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_comb
    begin
        item_t n;
        n = '0;
        for (int i = 0; i < 4; i++)
        begin
            n.q[i] = s_tdata[32*i +: 32];
        end
        for (int i = 0; i < 3; i++)
        begin
            n.u[i]  = s_tdata[128 + 32*i +: 32];
            n.ud[i] = s_tdata[224 + 32*i +: 32];
        end
        pipe_next[ST_IN] = n;
    end

    // h * |udot|
    always_comb
    begin
        item_t       n;
        logic [31:0] ud_mag;
        n = pipe_reg[ST_PM - 1];
        for (int i = 0; i < 3; i++)
        begin
            ud_mag      = n.ud[i][31] ? -n.ud[i] : n.ud[i];
            n.ud_neg[i] = n.ud[i][31];
            n.pm[i]     = step_size_reg * ud_mag;
        end
        pipe_next[ST_PM] = n;
    end

    // Half-step velocity, rounded away from zero and saturated.
    always_comb
    begin
        item_t              n;
        logic [39:0]        half;
        logic signed [40:0] hs;
        logic signed [40:0] wsum;
        n = pipe_reg[ST_W - 1];
        for (int i = 0; i < 3; i++)
        begin
            half = 40'((n.pm[i] + 64'd16777216) >> 25);
            hs   = n.ud_neg[i] ? -$signed({1'b0, half}) : $signed({1'b0, half});
            wsum = $signed({{9{n.u[i][31]}}, n.u[i]}) + hs;
            if (wsum > 41'sd2147483647)
            begin
                n.w[i] = 32'h7FFF_FFFF;
            end
            else if (wsum < -41'sd2147483648)
            begin
                n.w[i] = 32'h8000_0000;
            end
            else
            begin
                n.w[i] = wsum[31:0];
            end
        end
        pipe_next[ST_W] = n;
    end

    always_comb
    begin
        item_t       n;
        logic [31:0] wm;
        n = pipe_reg[ST_SQ - 1];
        for (int i = 0; i < 3; i++)
        begin
            wm      = n.w[i][31] ? -n.w[i] : n.w[i];
            n.sq[i] = wm * wm;
        end
        pipe_next[ST_SQ] = n;
    end

    always_comb
    begin
        item_t n;
        n       = pipe_reg[ST_SUMSQ - 1];
        n.sumsq = n.sq[0] + n.sq[1] + n.sq[2];
        n.srem  = '0;
        n.mag   = '0;
        pipe_next[ST_SUMSQ] = n;
    end

    // Integer square root, two result bits per stage; mag holds the partial root.
    for (genvar g = 0; g < SQRT_STAGES; g++)
    begin : g_sqrt
        always_comb
        begin
            item_t       n;
            logic [34:0] rem_s;
            logic [34:0] trial;
            logic [1:0]  bits;
            n = pipe_reg[ST_SQRT + g - 1];
            for (int s = 0; s < 2; s++)
            begin
                bits  = n.sumsq[63 - 4*g - 2*s -: 2];
                rem_s = {n.srem[32:0], bits};
                trial = {1'b0, n.mag, 2'b01};
                if (rem_s >= trial)
                begin
                    n.srem = rem_s - trial;
                    n.mag  = {n.mag[30:0], 1'b1};
                end
                else
                begin
                    n.srem = rem_s;
                    n.mag  = {n.mag[30:0], 1'b0};
                end
            end
            pipe_next[ST_SQRT + g] = n;
        end
    end

    always_comb
    begin
        item_t n;
        n   = pipe_reg[ST_P - 1];
        n.p = step_size_reg * n.mag;
        pipe_next[ST_P] = n;
    end

    // Partial products of h*|w| times 2/pi.
    always_comb
    begin
        item_t n;
        n       = pipe_reg[ST_PP - 1];
        n.pp[0] = n.p[31:0]  * QTURN_C[31:0];
        n.pp[1] = n.p[31:0]  * QTURN_C[63:32];
        n.pp[2] = n.p[63:32] * QTURN_C[31:0];
        n.pp[3] = n.p[63:32] * QTURN_C[63:32];
        pipe_next[ST_PP] = n;
    end

    always_comb
    begin
        item_t n;
        n     = pipe_reg[ST_MID - 1];
        n.mid = {1'b0, n.pp[1]} + {1'b0, n.pp[2]};
        pipe_next[ST_MID] = n;
    end

    // Keep two quadrant bits and 32 fraction bits of the angle in quarter turns.
    always_comb
    begin
        item_t        n;
        logic [127:0] full;
        n      = pipe_reg[ST_TURN - 1];
        full   = {n.pp[3], 64'd0} + {31'd0, n.mid, 32'd0} + {64'd0, n.pp[0]};
        n.quad = full[110:109];
        n.frac = full[108:77];
        pipe_next[ST_TURN] = n;
    end

    always_comb
    begin
        item_t n;
        n      = pipe_reg[ST_FOLD - 1];
        n.fsel = (n.frac <= 32'h8000_0000);
        n.arg  = n.fsel ? {1'b0, n.frac} : ONE_Q32 - {1'b0, n.frac};
        pipe_next[ST_FOLD] = n;
    end

    always_comb
    begin
        item_t       n;
        logic [65:0] xw;
        n   = pipe_reg[ST_X - 1];
        xw  = n.arg * HALF_PI_Q32;
        n.x = xw[63:32];
        pipe_next[ST_X] = n;
    end

    always_comb
    begin
        item_t       n;
        logic [63:0] xx;
        n       = pipe_reg[ST_X2 - 1];
        xx      = n.x * n.x;
        n.x2    = xx[63:32];
        n.t_cos = ONE_Q32;
        n.t_sin = ONE_Q32;
        pipe_next[ST_X2] = n;
    end

    // Horner steps of both series; each term takes multiply, reciprocal, correct.
    for (genvar j = 0; j < TRIG_SLOTS; j++)
    begin : g_trig
        localparam logic [33:0] M_COS = 34'((35'd1 << RECIP_SHIFT) / COS_K[j]);

        always_comb
        begin
            item_t n;
            n          = pipe_reg[ST_TRIG + 3*j - 1];
            n.prod_cos = n.x2 * n.t_cos;
            if (j > 0)
            begin
                n.prod_sin = n.x2 * n.t_sin;
            end
            pipe_next[ST_TRIG + 3*j] = n;
        end

        if (j == 0)
        begin : g_cos_only
            always_comb
            begin
                item_t n;
                n        = pipe_reg[ST_TRIG + 3*j];
                n.mr_cos = n.prod_cos[64:32] * M_COS;
                pipe_next[ST_TRIG + 3*j + 1] = n;
            end

            always_comb
            begin
                item_t n;
                n       = pipe_reg[ST_TRIG + 3*j + 1];
                n.t_cos = taylor_term(n.prod_cos, n.mr_cos, COS_K[j]);
                pipe_next[ST_TRIG + 3*j + 2] = n;
            end
        end
        else
        begin : g_both
            localparam logic [33:0] M_SIN = 34'((35'd1 << RECIP_SHIFT) / SIN_K[j-1]);

            always_comb
            begin
                item_t n;
                n        = pipe_reg[ST_TRIG + 3*j];
                n.mr_cos = n.prod_cos[64:32] * M_COS;
                n.mr_sin = n.prod_sin[64:32] * M_SIN;
                pipe_next[ST_TRIG + 3*j + 1] = n;
            end

            always_comb
            begin
                item_t n;
                n       = pipe_reg[ST_TRIG + 3*j + 1];
                n.t_cos = taylor_term(n.prod_cos, n.mr_cos, COS_K[j]);
                n.t_sin = taylor_term(n.prod_sin, n.mr_sin, SIN_K[j-1]);
                pipe_next[ST_TRIG + 3*j + 2] = n;
            end
        end
    end

    always_comb
    begin
        item_t       n;
        logic [64:0] sx;
        n       = pipe_reg[ST_SIN - 1];
        sx      = n.x * n.t_sin;
        n.t_sin = sx[64:32];
        pipe_next[ST_SIN] = n;
    end

    // Undo the fold and apply the quadrant; start the vector-part numerators.
    always_comb
    begin
        item_t       n;
        logic [32:0] s0;
        logic [32:0] c0;
        logic [32:0] cs_mag;
        logic [31:0] am;
        logic [31:0] wm;
        n          = pipe_reg[ST_SGN - 1];
        s0         = n.fsel ? n.t_sin : n.t_cos;
        c0         = n.fsel ? n.t_cos : n.t_sin;
        n.sn_mag   = n.quad[0] ? c0 : s0;
        n.sn_neg   = n.quad[1];
        cs_mag     = n.quad[0] ? s0 : c0;
        am         = 32'((cs_mag + 33'd2) >> 2);
        n.mag_zero = (n.mag == 32'd0);
        if (n.mag_zero)
        begin
            n.a = ONE_Q30;
        end
        else
        begin
            n.a = (n.quad[0] ^ n.quad[1]) ? -am : am;
        end
        for (int i = 0; i < 3; i++)
        begin
            wm       = n.w[i][31] ? -n.w[i] : n.w[i];
            n.num[i] = 64'(n.sn_mag) * 64'(wm);
        end
        n.den = {n.mag, 2'b00};
        pipe_next[ST_SGN] = n;
    end

    always_comb
    begin
        item_t n;
        n = pipe_reg[ST_NUM - 1];
        for (int i = 0; i < 3; i++)
        begin
            n.num[i]  = n.num[i] + {31'd0, n.mag, 1'b0};
            n.drem[i] = {3'd0, n.num[i][63:32]};
            n.quo[i]  = '0;
        end
        pipe_next[ST_NUM] = n;
    end

    // Rounded quotient |sin|*|w_i| / (4|w|), two quotient bits per stage.
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        always_comb
        begin
            item_t       n;
            logic [34:0] r_s;
            n = pipe_reg[ST_DIV + g - 1];
            for (int i = 0; i < 3; i++)
            begin
                for (int s = 0; s < 2; s++)
                begin
                    r_s = {n.drem[i][33:0], n.num[i][31 - 2*g - s]};
                    if (r_s >= {1'b0, n.den})
                    begin
                        n.drem[i] = r_s - {1'b0, n.den};
                        n.quo[i]  = {n.quo[i][30:0], 1'b1};
                    end
                    else
                    begin
                        n.drem[i] = r_s;
                        n.quo[i]  = {n.quo[i][30:0], 1'b0};
                    end
                end
            end
            pipe_next[ST_DIV + g] = n;
        end
    end

    // Sixteen products of the Hamilton product.
    always_comb
    begin
        item_t            n;
        logic [3:0][31:0] inc;
        n      = pipe_reg[ST_MUL - 1];
        inc[0] = n.a;
        for (int i = 0; i < 3; i++)
        begin
            if (n.mag_zero)
            begin
                inc[i+1] = '0;
            end
            else
            begin
                inc[i+1] = (n.sn_neg ^ n.w[i][31]) ? -n.quo[i] : n.quo[i];
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                n.prod[4*i + k] = 64'($signed(inc[i])) * 64'($signed(n.q[k]));
            end
        end
        pipe_next[ST_MUL] = n;
    end

    always_comb
    begin
        item_t                 n;
        logic [15:0][65:0]     px;
        n = pipe_reg[ST_SUM - 1];
        for (int i = 0; i < 16; i++)
        begin
            px[i] = {{2{n.prod[i][63]}}, n.prod[i]};
        end
        n.sum[0] = px[0]  - px[5]  - px[10] - px[15];
        n.sum[1] = px[1]  + px[4]  + px[11] - px[14];
        n.sum[2] = px[2]  + px[8]  + px[13] - px[7];
        n.sum[3] = px[3]  + px[12] + px[6]  - px[9];
        pipe_next[ST_SUM] = n;
    end

    // Round half up to Q2.30 and saturate.
    always_comb
    begin
        logic signed [65:0] rr;
        logic signed [35:0] sh;
        for (int i = 0; i < 4; i++)
        begin
            rr = $signed(pipe_reg[ST_LAST].sum[i]) + 66'sd536870912;
            sh = 36'(rr >>> 30);
            if (sh > 36'sd2147483647)
            begin
                out_next[i] = 32'h7FFF_FFFF;
            end
            else if (sh < -36'sd2147483648)
            begin
                out_next[i] = 32'h8000_0000;
            end
            else
            begin
                out_next[i] = sh[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NSTAGE; k++)
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
        if (en && valid_reg[ST_LAST])
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                valid_reg <= {valid_reg[NSTAGE-2:0], s_tvalid};
            end
            if (en && valid_reg[ST_LAST])
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    a_free_output_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid_reg |-> s_tready)
        else $error("input refused while the output register is empty");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[ST_IN])
        else $error("accepted transfer did not enter the pipeline");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(valid_reg[ST_LAST]))
        else $error("result appeared without a finished item");

    a_sqrt_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_P - 1] |->
            ({32'd0, pipe_reg[ST_P - 1].mag} * {32'd0, pipe_reg[ST_P - 1].mag}
                <= pipe_reg[ST_P - 1].sumsq) &&
            ({33'd0, pipe_reg[ST_P - 1].mag} + 65'd1) * ({33'd0, pipe_reg[ST_P - 1].mag} + 65'd1)
                > {1'b0, pipe_reg[ST_P - 1].sumsq})
        else $error("square root out of bounds");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_MUL - 1] && !pipe_reg[ST_MUL - 1].mag_zero) |->
            (pipe_reg[ST_MUL - 1].drem[0] < {1'b0, pipe_reg[ST_MUL - 1].den}) &&
            (pipe_reg[ST_MUL - 1].drem[1] < {1'b0, pipe_reg[ST_MUL - 1].den}) &&
            (pipe_reg[ST_MUL - 1].drem[2] < {1'b0, pipe_reg[ST_MUL - 1].den}))
        else $error("divider remainder not below the divisor");

endmodule
